// File: hdl/assert_macros.svh
// Assertion shorthands shared by the colormap RTL.
// Each expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while in reset.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication, sampled on clk, off while in reset.
`define CHK_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// File: hdl/chsl_pkg.sv
package chsl_pkg;

  // Default geometry of the block
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int COLOR_BITS_DEF  = 8;

  // Range register
  localparam int              RANGE_W     = 15;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 15'd2560;

  // Mapped value v is Q0.16, one is 2^16
  localparam int FRAC_W = 16;
  localparam logic [FRAC_W:0] ONE_Q = {1'b1, {FRAC_W{1'b0}}};

  // Divider: quotient bits resolved per pipeline stage
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = FRAC_W / DIV_BITS_PER_STAGE;

  // Hue sectors of 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } hue_sector_t;

  // Beat travelling through the divider stages
  typedef struct packed {
    logic              clamp_zero;
    logic              clamp_one;
    logic [FRAC_W-1:0] rem;
    logic [FRAC_W-1:0] div;
    logic [FRAC_W-1:0] quo;
  } chsl_div_t;

endpackage

// File: hdl/chsl_map.sv
`include "assert_macros.svh"

module chsl_map #(
  parameter int VALUE_WIDTH = chsl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [VALUE_WIDTH-1:0]        scalar_value,
  input  logic [chsl_pkg::RANGE_W-1:0]  color_range,
  output logic                          valid_out,
  output chsl_pkg::chsl_div_t           data_out
);
  import chsl_pkg::*;

  localparam int NUM_W = ((VALUE_WIDTH > FRAC_W) ? VALUE_WIDTH : FRAC_W) + 1;

  logic [RANGE_W-1:0] rng;
  logic [FRAC_W-1:0]  dvsr;
  logic [NUM_W-1:0]   val_ext;
  logic [NUM_W-1:0]   rng_ext;
  logic [NUM_W-1:0]   dvsr_ext;
  logic [NUM_W-1:0]   num;
  logic               num_neg;
  chsl_div_t          data_nxt;
  logic               valid_r;
  chsl_div_t          data_r;

  always_comb begin
    // zero range behaves as the smallest legal range
    rng      = (color_range == '0) ? RANGE_W'(1) : color_range;
    dvsr     = {rng, 1'b0};
    val_ext  = {{(NUM_W-VALUE_WIDTH){scalar_value[VALUE_WIDTH-1]}}, scalar_value};
    rng_ext  = {{(NUM_W-RANGE_W){1'b0}}, rng};
    dvsr_ext = {{(NUM_W-FRAC_W){1'b0}}, dvsr};
    num      = rng_ext + val_ext;
    num_neg  = num[NUM_W-1];

    data_nxt.clamp_zero = num_neg || (num == '0);
    data_nxt.clamp_one  = !num_neg && (num >= dvsr_ext);
    data_nxt.div        = dvsr;
    data_nxt.quo        = '0;
    // clamped beats carry a dead remainder
    if (data_nxt.clamp_zero || data_nxt.clamp_one) begin
      data_nxt.rem = '0;
    end else begin
      data_nxt.rem = num[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

  `CHK_IMPLY(a_clamp_excl, valid_r, !(data_r.clamp_zero && data_r.clamp_one), "both clamps set")

endmodule

// File: hdl/chsl_div_step.sv
`include "assert_macros.svh"

module chsl_div_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_in,
  input  chsl_pkg::chsl_div_t data_in,
  output logic                valid_out,
  output chsl_pkg::chsl_div_t data_out
);
  import chsl_pkg::*;

  chsl_div_t data_nxt;
  logic      valid_r;
  chsl_div_t data_r;

  // Restoring division, a few quotient bits per stage
  always_comb begin
    logic [FRAC_W+1:0] trial;
    logic              ge;
    data_nxt = data_in;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      trial = {1'b0, data_nxt.rem, 1'b0} - {2'b00, data_nxt.div};
      ge    = !trial[FRAC_W+1];
      if (ge) begin
        data_nxt.rem = trial[FRAC_W-1:0];
      end else begin
        data_nxt.rem = {data_nxt.rem[FRAC_W-2:0], 1'b0};
      end
      data_nxt.quo = {data_nxt.quo[FRAC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

  `CHK_IMPLY(a_rem_below_div, valid_r && !data_r.clamp_zero && !data_r.clamp_one, data_r.rem < data_r.div, "remainder not below divisor")

endmodule

// File: hdl/chsl_color.sv
`include "assert_macros.svh"

module chsl_color #(
  parameter int COLOR_BITS = chsl_pkg::COLOR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_in,
  input  chsl_pkg::chsl_div_t   data_in,
  output logic                  valid_out,
  output logic [COLOR_BITS-1:0] red,
  output logic [COLOR_BITS-1:0] green,
  output logic [COLOR_BITS-1:0] blue
);
  import chsl_pkg::*;

  localparam int HUE_W  = FRAC_W + 3;
  localparam int CP_W   = FRAC_W + 1 + COLOR_BITS + 1;
  localparam int PROD_W = 2 * (FRAC_W + 1);
  localparam int XP_W   = PROD_W + COLOR_BITS + 1;

  // stage 1: v, sector, triangle
  logic [FRAC_W:0]   v_nxt;
  logic [FRAC_W:0]   inv;
  logic [HUE_W-1:0]  hue;
  logic [FRAC_W-1:0] frac;
  logic [FRAC_W:0]   t_nxt;
  hue_sector_t       sector_nxt;
  logic              s1_valid_r;
  logic [FRAC_W:0]   s1_v_r;
  logic [FRAC_W:0]   s1_t_r;
  hue_sector_t       s1_sector_r;

  // stage 2: v*t and rounded chroma
  logic [CP_W-1:0]       cprod;
  logic                  s2_valid_r;
  logic [PROD_W-1:0]     s2_prod_r;
  logic [COLOR_BITS-1:0] s2_c_r;
  hue_sector_t           s2_sector_r;

  // stage 3: rounded secondary, channel routing
  logic [XP_W-1:0]       xprod;
  logic [COLOR_BITS-1:0] x_val;
  logic [COLOR_BITS-1:0] red_nxt;
  logic [COLOR_BITS-1:0] green_nxt;
  logic [COLOR_BITS-1:0] blue_nxt;
  logic                  s3_valid_r;
  logic [COLOR_BITS-1:0] red_r;
  logic [COLOR_BITS-1:0] green_r;
  logic [COLOR_BITS-1:0] blue_r;

  always_comb begin
    if (data_in.clamp_one) begin
      v_nxt = ONE_Q;
    end else if (data_in.clamp_zero) begin
      v_nxt = '0;
    end else begin
      v_nxt = {1'b0, data_in.quo};
    end
    inv        = ONE_Q - v_nxt;
    hue        = {inv, 2'b00};
    sector_nxt = hue_sector_t'(hue[HUE_W-1:FRAC_W]);
    frac       = hue[FRAC_W-1:0];
    // fold odd sectors back down
    if (hue[FRAC_W]) begin
      t_nxt = ONE_Q - {1'b0, frac};
    end else begin
      t_nxt = {1'b0, frac};
    end
  end

  always_comb begin
    cprod = CP_W'({s1_v_r, {COLOR_BITS{1'b0}}}) - CP_W'(s1_v_r)
          + (CP_W'(1) << (FRAC_W - 1));
  end

  always_comb begin
    xprod = XP_W'({s2_prod_r, {COLOR_BITS{1'b0}}}) - XP_W'(s2_prod_r)
          + (XP_W'(1) << (2 * FRAC_W - 1));
    x_val = xprod[2*FRAC_W +: COLOR_BITS];
    case (s2_sector_r)
      SEC_RED_YEL: begin
        red_nxt = s2_c_r; green_nxt = x_val;  blue_nxt = '0;
      end
      SEC_YEL_GRN: begin
        red_nxt = x_val;  green_nxt = s2_c_r; blue_nxt = '0;
      end
      SEC_GRN_CYN: begin
        red_nxt = '0;     green_nxt = s2_c_r; blue_nxt = x_val;
      end
      SEC_CYN_BLU: begin
        red_nxt = '0;     green_nxt = x_val;  blue_nxt = s2_c_r;
      end
      SEC_BLU_MAG: begin
        red_nxt = x_val;  green_nxt = '0;     blue_nxt = s2_c_r;
      end
      SEC_MAG_RED: begin
        red_nxt = s2_c_r; green_nxt = '0;     blue_nxt = x_val;
      end
      default: begin
        red_nxt = '0;     green_nxt = '0;     blue_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= valid_in;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v_r      <= v_nxt;
      s1_t_r      <= t_nxt;
      s1_sector_r <= sector_nxt;
      s2_prod_r   <= s1_v_r * s1_t_r;
      s2_c_r      <= cprod[FRAC_W +: COLOR_BITS];
      s2_sector_r <= s1_sector_r;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
    end
  end

  assign valid_out = s3_valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

  `CHK_IMPLY(a_blue_mag_only_at_zero, s1_valid_r && (s1_sector_r == SEC_BLU_MAG), s1_v_r == '0, "sector four with nonzero v")

endmodule

// File: hdl/curvature_hsl_colormap_unit.sv
// Channel | Ports                                   | Handshake
// --------+-----------------------------------------+---------------------------
// in      | in_scalar_value                         | in_valid / in_stall
// out     | out_red, out_green, out_blue            | out_valid / out_stall
// cfg     | cfg_write_data                          | cfg_write_en, no wait
//
// One beat per clock in steady state while out is not stalled; a result passes
// through 1 range/clamp stage, 8 divider stages of 2 quotient bits each and 3
// color stages ending in the output register. Most stages belong to the
// restoring divider that forms v = num / (2*range).
// Reset is synchronous, active low; it clears all valid bits and loads the
// range register with 10.0 (Q7.8).
// A stall on out while out_valid is high freezes every stage at once; in_stall follows it directly.
`include "assert_macros.svh"

module curvature_hsl_colormap_unit #(
  parameter int VALUE_WIDTH = chsl_pkg::VALUE_WIDTH_DEF,
  parameter int COLOR_BITS  = chsl_pkg::COLOR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [VALUE_WIDTH-1:0]       in_scalar_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COLOR_BITS-1:0]        out_red,
  output logic [COLOR_BITS-1:0]        out_green,
  output logic [COLOR_BITS-1:0]        out_blue,
  // configuration
  input  logic                         cfg_write_en,
  input  logic [chsl_pkg::RANGE_W-1:0] cfg_write_data
);
  import chsl_pkg::*;

  logic [RANGE_W-1:0]  color_range_r;
  logic                adv;
  logic [DIV_STAGES:0] div_valid;
  chsl_div_t           div_data [DIV_STAGES+1];

  // Range register; user must write only while the pipe is empty, not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_range_r <= RANGE_RESET;
    end else if (cfg_write_en) begin
      color_range_r <= cfg_write_data;
    end
  end

  // Advance the whole pipe unless the output beat is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Offset the scalar by the range, decide the clamps, seed the divider
  chsl_map #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_map (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .valid_in     (in_valid),
    .scalar_value (in_scalar_value),
    .color_range  (color_range_r),
    .valid_out    (div_valid[0]),
    .data_out     (div_data[0])
  );

  // Divider stages: each resolves a couple of quotient bits of v
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    chsl_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .valid_in  (div_valid[s]),
      .data_in   (div_data[s]),
      .valid_out (div_valid[s+1]),
      .data_out  (div_data[s+1])
    );
  end

  // Hue sector, chroma and secondary component, then the output register
  chsl_color #(
    .COLOR_BITS (COLOR_BITS)
  ) u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .valid_in  (div_valid[DIV_STAGES]),
    .data_in   (div_data[DIV_STAGES]),
    .valid_out (out_valid),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue)
  );

  // Hold every divider valid bit across a stalled cycle
  `CHK_ASSERT(a_pipe_hold, !adv |=> $stable(div_valid), "divider pipe moved during stall")

endmodule
